>>> sv/crc32_reflected_byte_engine_macros.svh
// Assertion shorthands used by the checker file.
`ifndef CRC32_REFLECTED_BYTE_ENGINE_MACROS_SVH
`define CRC32_REFLECTED_BYTE_ENGINE_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

`endif

>>> sv/crcrbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crcrbe_pkg;

    localparam int unsigned CRC_WIDTH  = 32;
    localparam int unsigned BYTE_WIDTH = 8;
    localparam int unsigned CFG_INDEX_WIDTH = 2;

    localparam logic [CRC_WIDTH-1:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [CRC_WIDTH-1:0] CRC_XOROUT = 32'hFFFF_FFFF;
    localparam logic [CRC_WIDTH-1:0] POLY_RESET = 32'h1EDC_6F41;
    localparam logic [CRC_WIDTH-1:0] EXP1_RESET = 32'hE168_0293;
    localparam logic [CRC_WIDTH-1:0] EXP2_RESET = 32'hEF34_F989;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POLYNOMIAL      = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXPECTED_FIRST  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXPECTED_SECOND = 2'd2;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] data_byte;
        logic                  is_last;
    } in_item_t;

    typedef struct packed {
        logic [CRC_WIDTH-1:0] crc_value;
        logic                 is_final;
        logic                 matches_expected;
    } out_item_t;

    // Result of one byte step: the item to deliver and the register update.
    typedef struct packed {
        out_item_t            result;
        logic [CRC_WIDTH-1:0] crc_next;
    } step_out_t;

endpackage

`default_nettype wire

>>> sv/crc32_reflected_byte_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                                      Handshake
// in        input      data_byte, is_last                           in_valid / in_ready
// out       output     crc_value, is_final, matches_expected        out_valid / out_ready
// cfg       input      cfg_index (0 poly, 1 exp first, 2 exp second) cfg_valid / cfg_ready
//
// One byte per clock unless out stalls; a byte moves from input to output register.
// The byte step (xor plus eight shift/xor steps) runs between the input register and
// the output register, and the CRC register closes its loop in that same cycle.
// Reset loads the CRC register with all ones and the config registers with defaults.
// A stalled output holds the input register; in_ready stays high while either is free.
// cfg_ready is always high; writes to an unused index are dropped.
module crc32_reflected_byte_engine (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire crcrbe_pkg::in_item_t                    in_item,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output crcrbe_pkg::out_item_t                        out_item,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [crcrbe_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [crcrbe_pkg::CRC_WIDTH-1:0]        cfg_data
);
    import crcrbe_pkg::*;

    in_item_t             in_item_reg;
    logic                 in_valid_reg;
    out_item_t            out_item_reg;
    logic                 out_valid_reg;
    logic [CRC_WIDTH-1:0] crc_reg;
    logic [CRC_WIDTH-1:0] poly_reg;
    logic [CRC_WIDTH-1:0] exp1_reg;
    logic [CRC_WIDTH-1:0] exp2_reg;

    step_out_t            step;
    logic                 out_load;
    logic                 in_load;

    crcrbe_step u_step (
        .crc             (crc_reg),
        .item            (in_item_reg),
        .polynomial      (poly_reg),
        .expected_first  (exp1_reg),
        .expected_second (exp2_reg),
        .step            (step)
    );

    assign out_load  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || !out_valid_reg || out_ready;
    assign in_load   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= CRC_INIT;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                crc_reg       <= step.crc_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_item_reg <= in_item;
        end
        if (out_load)
        begin
            out_item_reg <= step.result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= POLY_RESET;
            exp1_reg <= EXP1_RESET;
            exp2_reg <= EXP2_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POLYNOMIAL:      poly_reg <= cfg_data;
                CFG_EXPECTED_FIRST:  exp1_reg <= cfg_data;
                CFG_EXPECTED_SECOND: exp2_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/crcrbe_step.sv
`timescale 1ns / 1ps
`default_nettype none

module crcrbe_step (
    input  wire logic [crcrbe_pkg::CRC_WIDTH-1:0] crc,
    input  wire crcrbe_pkg::in_item_t             item,
    input  wire logic [crcrbe_pkg::CRC_WIDTH-1:0] polynomial,
    input  wire logic [crcrbe_pkg::CRC_WIDTH-1:0] expected_first,
    input  wire logic [crcrbe_pkg::CRC_WIDTH-1:0] expected_second,
    output crcrbe_pkg::step_out_t                 step
);
    import crcrbe_pkg::*;

    logic [CRC_WIDTH-1:0] work;
    logic [CRC_WIDTH-1:0] value;

    // Fold the byte into the low bits, then eight right shifts.
    always_comb
    begin
        work = crc ^ {{(CRC_WIDTH-BYTE_WIDTH){1'b0}}, item.data_byte};
        for (int k = 0; k < BYTE_WIDTH; k++)
        begin
            work = (work >> 1) ^ (polynomial & {CRC_WIDTH{work[0]}});
        end
    end

    assign value = work ^ CRC_XOROUT;

    always_comb
    begin
        step.result.crc_value        = value;
        step.result.is_final         = item.is_last;
        step.result.matches_expected = item.is_last &&
                                       ((value == expected_first) ||
                                        (value == expected_second));
        // Reload for the next message after its last byte.
        step.crc_next                = item.is_last ? CRC_INIT : work;
    end

endmodule

`default_nettype wire

>>> sv/crcrbe_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "crc32_reflected_byte_engine_macros.svh"

module crcrbe_checker (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    input  wire logic                                    in_ready,
    input  wire crcrbe_pkg::in_item_t                    in_item,
    input  wire logic                                    out_valid,
    input  wire logic                                    out_ready,
    input  wire crcrbe_pkg::out_item_t                   out_item,
    input  wire logic                                    cfg_valid,
    input  wire logic                                    cfg_ready,
    input  wire logic [crcrbe_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [crcrbe_pkg::CRC_WIDTH-1:0]        cfg_data
);
    import crcrbe_pkg::*;

    // Hold a stalled result.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))

    // Only a closing result may flag a match.
    `ASSERT_IMPLIES(a_match_final, clk, rst_n, out_valid && !out_item.is_final, !out_item.matches_expected)

    // An accepted byte reaches the output once the output register is free to load it.
    `ASSERT_NEXT(a_byte_latency, clk, rst_n, (in_valid && in_ready) ##1 out_ready, out_valid)

    // An empty output never blocks input.
    `ASSERT_IMPLIES(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

endmodule

bind crc32_reflected_byte_engine crcrbe_checker u_checker (.*);

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import crcrbe_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;
    localparam logic [CRC_WIDTH-1:0] IEEE_POLY_REFLECTED = 32'hEDB8_8320;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned SETTLE_CYCLES = 8;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    in_item_t                    in_item = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    out_item_t                   out_item;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]  cfg_index = '0;
    logic [CRC_WIDTH-1:0]        cfg_data = '0;

    // Predictor state: running CRC and its own copy of the registers.
    logic [CRC_WIDTH-1:0]        crc_state = CRC_INIT;
    logic [CRC_WIDTH-1:0]        poly_cfg = POLY_RESET;
    logic [CRC_WIDTH-1:0]        exp_first_cfg = EXP1_RESET;
    logic [CRC_WIDTH-1:0]        exp_second_cfg = EXP2_RESET;
    out_item_t                   crc_results_due[$];

    int unsigned                 mismatch_count = 0;
    int unsigned                 cycle_count = 0;
    int unsigned                 hold_cycles_left = 0;
    int unsigned                 rx_stall_left = 0;
    logic                        tx_steady = 1'b0;
    logic                        rx_steady = 1'b0;

    crc32_reflected_byte_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("crc32_reflected_byte_engine: mismatch");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    function automatic logic [CRC_WIDTH-1:0] pick_word();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CRC_WIDTH-1:0] pick_poly();
        case ($urandom_range(3))
            0: return POLY_RESET;
            1: return IEEE_POLY_REFLECTED;
            default: return pick_word();
        endcase
    endfunction

    // Eight right shifts, folding in the polynomial whenever bit 0 falls out set.
    function automatic logic [CRC_WIDTH-1:0] advance_crc(input logic [CRC_WIDTH-1:0] crc,
                                                         input logic [BYTE_WIDTH-1:0] b,
                                                         input logic [CRC_WIDTH-1:0] poly);
        logic [CRC_WIDTH-1:0] r;
        r = crc ^ {{(CRC_WIDTH-BYTE_WIDTH){1'b0}}, b};
        for (int k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
        return r;
    endfunction

    // Reported CRC if b were the next byte, from the current predictor state.
    function automatic logic [CRC_WIDTH-1:0] reported_crc_for(input logic [BYTE_WIDTH-1:0] b);
        return advance_crc(crc_state, b, poly_cfg) ^ CRC_XOROUT;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Receiver: long hold-off on request, always ready in steady mode, otherwise random stalls.
    always @(posedge clk)
    begin
        if (hold_cycles_left > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles_left--;
        end
        else if (rx_steady)
            out_ready <= 1'b1;
        else if (rx_stall_left > 0)
        begin
            out_ready <= 1'b0;
            rx_stall_left--;
        end
        else
        begin
            rx_stall_left = ($urandom_range(3) == 0) ? pick_gap() : 0;
            out_ready <= (rx_stall_left == 0);
        end
    end

    // Sample at the falling edge: the handshake seen here completes at the next rising edge.
    always @(negedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (crc_results_due.size() == 0)
                report_mismatch($sformatf("unexpected item, crc_value %h", out_item.crc_value));
            else
            begin
                want = crc_results_due.pop_front();
                if (out_item.crc_value !== want.crc_value)
                    report_mismatch($sformatf("crc_value %h, predicted %h",
                                              out_item.crc_value, want.crc_value));
                if (out_item.is_final !== want.is_final)
                    report_mismatch($sformatf("is_final %b, predicted %b",
                                              out_item.is_final, want.is_final));
                if (out_item.matches_expected !== want.matches_expected)
                    report_mismatch($sformatf("matches_expected %b, predicted %b (crc %h)",
                                              out_item.matches_expected,
                                              want.matches_expected, want.crc_value));
            end
        end
    end

    // Leaves in_valid high after acceptance so back-to-back items keep in_valid asserted between them.
    task automatic send_byte(input logic [BYTE_WIDTH-1:0] b, input logic last);
        int unsigned gap;
        in_item_t    item;
        out_item_t   res;
        gap = tx_steady ? 0 : pick_gap();
        item.data_byte = b;
        item.is_last = last;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        crc_state = advance_crc(crc_state, b, poly_cfg);
        res.crc_value = crc_state ^ CRC_XOROUT;
        res.is_final = last;
        res.matches_expected = last && (res.crc_value == exp_first_cfg ||
                                        res.crc_value == exp_second_cfg);
        if (last)
            crc_state = CRC_INIT;
        crc_results_due.push_back(res);
    endtask

    // Every item yields one result, so an empty queue means the block is idle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (crc_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CRC_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_POLYNOMIAL:      poly_cfg = value;
            CFG_EXPECTED_FIRST:  exp_first_cfg = value;
            CFG_EXPECTED_SECOND: exp_second_cfg = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic test_single_byte_extremes();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
    endtask

    task automatic test_check_string();
        for (int i = 1; i <= 9; i++)
            send_byte(8'(8'h30 + i), i == 9);
    endtask

    task automatic test_match_flags();
        drain();
        write_reg(CFG_EXPECTED_FIRST, reported_crc_for(8'hA5));
        send_byte(8'hA5, 1'b1);
        drain();
        write_reg(CFG_EXPECTED_SECOND, reported_crc_for(8'h3C));
        send_byte(8'h3C, 1'b1);
        // same value on a byte that does not close the message: flag stays low
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b1);
    endtask

    task automatic test_unused_index();
        drain();
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_config_mid_message();
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        drain();
        write_reg(CFG_POLYNOMIAL, IEEE_POLY_REFLECTED);
        send_byte(8'h56, 1'b1);
        drain();
        write_reg(CFG_POLYNOMIAL, '0);
        write_reg(CFG_EXPECTED_SECOND, '1);
        write_reg(CFG_EXPECTED_FIRST, '0);
        for (int i = 0; i < 4; i++)
            send_byte(8'hFF, i == 3);
        drain();
        write_reg(CFG_POLYNOMIAL, '1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        drain();
        write_reg(CFG_POLYNOMIAL, POLY_RESET);
        write_reg(CFG_EXPECTED_FIRST, EXP1_RESET);
        write_reg(CFG_EXPECTED_SECOND, EXP2_RESET);
    endtask

    task automatic test_output_backpressure();
        drain();
        tx_steady = 1'b1;
        hold_cycles_left = 200;
        for (int i = 0; i < 48; i++)
            send_byte(8'($urandom), (i % 16) == 15);
        tx_steady = 1'b0;
    endtask

    task automatic test_random_stream();
        int unsigned      sent;
        int unsigned      phase_len;
        int unsigned      msg_left;
        logic [BYTE_WIDTH-1:0] b;
        sent = 0;
        msg_left = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain();
            tx_steady = ($urandom_range(3) == 0);
            rx_steady = ($urandom_range(3) == 0);
            if ($urandom_range(1))
                write_reg(CFG_POLYNOMIAL, pick_poly());
            if ($urandom_range(3) == 0)
                write_reg(CFG_UNUSED, $urandom);
            if ($urandom_range(1))
                write_reg(CFG_EXPECTED_FIRST, pick_word());
            if ($urandom_range(1))
                write_reg(CFG_EXPECTED_SECOND, pick_word());
            // between messages, may open the phase with a one-byte message aimed at one of the expected values
            if (msg_left == 0 && $urandom_range(2) != 0)
            begin
                b = 8'($urandom);
                if ($urandom_range(1))
                    write_reg(CFG_EXPECTED_FIRST, reported_crc_for(b));
                else
                    write_reg(CFG_EXPECTED_SECOND, reported_crc_for(b));
                send_byte(b, 1'b1);
                sent++;
            end
            phase_len = $urandom_range(160, 40);
            for (int i = 0; i < phase_len; i++)
            begin
                if (msg_left == 0)
                    msg_left = ($urandom_range(7) == 0) ? $urandom_range(48, 13)
                                                        : $urandom_range(12, 1);
                send_byte(8'($urandom), msg_left == 1);
                msg_left--;
                sent++;
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_byte_extremes();
        test_check_string();
        test_match_flags();
        test_unused_index();
        test_config_mid_message();
        test_output_backpressure();
        test_random_stream();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("crc32_reflected_byte_engine: match");
        else
            $display("crc32_reflected_byte_engine: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/crcrbe_pkg.sv
sv/crcrbe_step.sv
sv/crc32_reflected_byte_engine.sv
sv/crcrbe_checker.sv
dv/tb_top.sv
